// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the stack ALU modules.
// Every check is sampled on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU package
// Word layouts, operation and status codes, and the request and response
// bundles between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package smalu_pkg;

    localparam int VALUE_W = 32;
    localparam int DEPTH_W = 7;
    localparam int KIND_W  = 3;

    typedef logic [KIND_W-1:0]         t_kind;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [DEPTH_W-1:0]        t_depth;

    localparam t_kind KIND_PUSH = 3'd0;
    localparam t_kind KIND_ADD  = 3'd1;
    localparam t_kind KIND_MUL  = 3'd2;
    localparam t_kind KIND_DIV  = 3'd3;
    localparam t_kind KIND_SUB  = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2,
        STATUS_DIV_ZERO  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_alu_rsp;

    typedef struct packed {
        t_kind  kind;
        t_value immediate;
    } t_in_word;

    typedef struct packed {
        t_value  top_value;
        t_status status;
        t_depth  depth;
    } t_out_word;

endpackage

// ===== hdl/smalu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module smalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/smalu_exec.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU shared arithmetic unit
// One adder/subtractor does add and subtract in a single pass, multiply by
// shift and add one bit per cycle, and signed divide by restoring division
// one quotient bit per cycle, with sign handling through the same adder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smalu_exec #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smalu_pkg::t_alu_req   i_req,
    input  logic [DATA_WIDTH-1:0] i_first,
    input  logic [DATA_WIDTH-1:0] i_second,
    output smalu_pkg::t_alu_rsp   o_rsp,
    output logic [DATA_WIDTH-1:0] o_result
);

    localparam int CW = $clog2(DATA_WIDTH);
    localparam int SW = DATA_WIDTH + 2;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ADD  = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ABSA = 8'b0000_1000,
        S_ABSB = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIX  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_exec_state;

    t_exec_state           r_state, n_state;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_sub, n_sub;
    logic                  r_neg, n_neg;

    logic [DATA_WIDTH:0]   op_x;
    logic [DATA_WIDTH:0]   op_y;
    logic                  op_sub;
    logic [SW-1:0]         sum;
    logic                  ge;

    // Operand selection for the one shared adder.
    always_comb begin
        op_x   = '0;
        op_y   = '0;
        op_sub = 1'b0;
        case (r_state)
            S_ADD: begin
                op_x   = {1'b0, r_x};
                op_y   = {1'b0, r_y};
                op_sub = r_sub;
            end
            S_MUL: begin
                op_x = {1'b0, r_acc};
                op_y = {1'b0, r_x};
            end
            S_ABSA: begin
                op_y   = {1'b0, r_x};
                op_sub = 1'b1;
            end
            S_ABSB: begin
                op_y   = {1'b0, r_y};
                op_sub = 1'b1;
            end
            S_DIV: begin
                op_x   = {r_acc, r_x[DATA_WIDTH-1]};
                op_y   = {1'b0, r_y};
                op_sub = 1'b1;
            end
            S_FIX: begin
                op_y   = {1'b0, r_x};
                op_sub = 1'b1;
            end
            default: begin
                op_sub = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, op_x} + {1'b0, op_y ^ {(DATA_WIDTH + 1){op_sub}}} + SW'(op_sub);
    // The carry out of a subtraction is set when the minuend is not below the subtrahend.
    assign ge  = sum[SW-1];

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_sub   = r_sub;
        n_neg   = r_neg;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_x   = i_first;
                    n_y   = i_second;
                    n_acc = '0;
                    n_cnt = CW'(DATA_WIDTH - 1);
                    n_sub = (i_req.op == smalu_pkg::ALU_SUB);
                    n_neg = i_first[DATA_WIDTH-1] ^ i_second[DATA_WIDTH-1];
                    case (i_req.op)
                        smalu_pkg::ALU_ADD: n_state = S_ADD;
                        smalu_pkg::ALU_SUB: n_state = S_ADD;
                        smalu_pkg::ALU_MUL: n_state = S_MUL;
                        smalu_pkg::ALU_DIV: n_state = S_ABSA;
                        default:            n_state = S_ADD;
                    endcase
                end
            end
            S_ADD: begin
                n_acc   = sum[DATA_WIDTH-1:0];
                n_state = S_DONE;
            end
            S_MUL: begin
                if (r_y[0]) begin
                    n_acc = sum[DATA_WIDTH-1:0];
                end
                n_x   = {r_x[DATA_WIDTH-2:0], 1'b0};
                n_y   = {1'b0, r_y[DATA_WIDTH-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_ABSA: begin
                if (r_x[DATA_WIDTH-1]) begin
                    n_x = sum[DATA_WIDTH-1:0];
                end
                n_state = S_ABSB;
            end
            S_ABSB: begin
                if (r_y[DATA_WIDTH-1]) begin
                    n_y = sum[DATA_WIDTH-1:0];
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                // The partial remainder stays below the divisor, so it fits the word.
                n_acc   = ge ? sum[DATA_WIDTH-1:0] : op_x[DATA_WIDTH-1:0];
                n_x     = {r_x[DATA_WIDTH-2:0], ge};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_acc   = r_neg ? sum[DATA_WIDTH-1:0] : r_x;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_cnt <= n_cnt;
        r_sub <= n_sub;
        r_neg <= n_neg;
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_result   = r_acc;

    `ASSERT_IMPLIES(a_start_when_idle, i_clk, i_rst_n, i_req.start, r_state == S_IDLE, "start while busy")
    `ASSERT_NEXT(a_div_iterates, i_clk, i_rst_n, r_state == S_DIV && r_cnt != '0, r_state == S_DIV, "divide left early")
    `ASSERT_NEXT(a_mul_iterates, i_clk, i_rst_n, r_state == S_MUL && r_cnt != '0, r_state == S_MUL, "multiply left early")

endmodule

// ===== hdl/stack_machine_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU
// Executes one push, add, multiply, divide or subtract per input word on a
// bounded operand stack and returns the new top, a status and the depth.
//
//   Channel | Direction | Handshake               | Word
//   --------+-----------+-------------------------+-----------
//   in      | input     | i_in_valid / o_in_ready | t_in_word
//   out     | output    | o_out_valid/i_out_ready | t_out_word
//
// Push, no-op, underflow and overflow go straight to writeback; divide by zero
// first passes operand fetch; add, subtract, multiply and divide pass operand
// fetch and the shared unit, where multiply and divide run one bit per cycle
// through the shared adder. The stack top is cached in a register and the
// entry below it comes from the stack RAM over its single registered read port.
// Reset clears the sequencer, the stack pointer and the output valid flag.
// A new word is accepted while the previous result waits; a stalled output
// holds the next result in writeback until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_machine_alu_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  smalu_pkg::t_in_word  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output smalu_pkg::t_out_word o_out
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_OPND = 4'b0010,
        T_EXEC = 4'b0100,
        T_WB   = 4'b1000
    } t_seq_state;

    t_seq_state            r_state, n_state;
    logic [SPW-1:0]        r_sp, n_sp;
    logic [DATA_WIDTH-1:0] r_top, n_top;
    logic [DATA_WIDTH-1:0] r_res, n_res;
    smalu_pkg::t_kind      r_kind, n_kind;
    smalu_pkg::t_status    r_status, n_status;
    logic                  r_apply, n_apply;
    logic                  r_out_valid, n_out_valid;
    smalu_pkg::t_out_word  r_out, n_out;

    logic                  in_accept;
    logic                  out_load;
    logic [SPW-1:0]        sp_m2;
    logic                  is_push;
    logic                  rd_en;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] second;
    smalu_pkg::t_alu_req   alu_req;
    smalu_pkg::t_alu_rsp   alu_rsp;
    logic [DATA_WIDTH-1:0] alu_result;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_load  = (r_state == T_WB) && (!r_out_valid || i_out_ready);
    assign sp_m2     = r_sp - SPW'(2);
    assign is_push   = (r_kind == smalu_pkg::KIND_PUSH);
    assign rd_en     = in_accept && (i_in.kind != smalu_pkg::KIND_PUSH)
                       && (i_in.kind <= smalu_pkg::KIND_SUB) && (r_sp >= SPW'(2));
    assign wr_en     = out_load && r_apply;
    assign wr_addr   = is_push ? r_sp[AW-1:0] : sp_m2[AW-1:0];

    smalu_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_res),
        .i_rd_en   (rd_en),
        .i_rd_addr (sp_m2[AW-1:0]),
        .o_rd_data (second)
    );

    smalu_exec #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_first  (r_top),
        .i_second (second),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = smalu_pkg::ALU_ADD;
        case (r_kind)
            smalu_pkg::KIND_ADD: alu_req.op = smalu_pkg::ALU_ADD;
            smalu_pkg::KIND_MUL: alu_req.op = smalu_pkg::ALU_MUL;
            smalu_pkg::KIND_DIV: alu_req.op = smalu_pkg::ALU_DIV;
            smalu_pkg::KIND_SUB: alu_req.op = smalu_pkg::ALU_SUB;
            default:             alu_req.op = smalu_pkg::ALU_ADD;
        endcase
        if (r_state == T_OPND) begin
            alu_req.start = !((r_kind == smalu_pkg::KIND_DIV) && (second == '0));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_top       = r_top;
        n_res       = r_res;
        n_kind      = r_kind;
        n_status    = r_status;
        n_apply     = r_apply;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            T_IDLE: begin
                if (in_accept) begin
                    n_kind   = i_in.kind;
                    n_res    = DATA_WIDTH'(i_in.immediate);
                    n_status = smalu_pkg::STATUS_OK;
                    n_apply  = 1'b0;
                    n_state  = T_WB;
                    case (i_in.kind)
                        smalu_pkg::KIND_PUSH: begin
                            if (r_sp == SPW'(STACK_DEPTH)) begin
                                n_status = smalu_pkg::STATUS_OVERFLOW;
                            end else begin
                                n_apply = 1'b1;
                            end
                        end
                        smalu_pkg::KIND_ADD, smalu_pkg::KIND_MUL,
                        smalu_pkg::KIND_DIV, smalu_pkg::KIND_SUB: begin
                            if (r_sp < SPW'(2)) begin
                                n_status = smalu_pkg::STATUS_UNDERFLOW;
                            end else begin
                                n_state = T_OPND;
                            end
                        end
                        default: begin
                            n_apply = 1'b0;
                        end
                    endcase
                end
            end
            T_OPND: begin
                if (alu_req.start) begin
                    n_state = T_EXEC;
                end else begin
                    n_status = smalu_pkg::STATUS_DIV_ZERO;
                    n_state  = T_WB;
                end
            end
            T_EXEC: begin
                if (alu_rsp.done) begin
                    n_res   = alu_result;
                    n_apply = 1'b1;
                    n_state = T_WB;
                end
            end
            T_WB: begin
                if (out_load) begin
                    if (r_apply) begin
                        n_top = r_res;
                        n_sp  = is_push ? r_sp + 1'b1 : r_sp - 1'b1;
                    end
                    n_out.top_value = (n_sp == '0) ? '0 : smalu_pkg::t_value'(n_top);
                    n_out.status    = r_status;
                    n_out.depth     = smalu_pkg::t_depth'(n_sp);
                    n_out_valid     = 1'b1;
                    n_state         = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_top    <= n_top;
        r_res    <= n_res;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_apply  <= n_apply;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == T_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_IMPLIES(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= SPW'(STACK_DEPTH), "stack pointer past depth")
    `ASSERT_IMPLIES(a_sp_moves_in_wb, i_clk, i_rst_n, !$stable(r_sp), $past(r_state == T_WB), "stack pointer moved outside writeback")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !o_in_ready, "ready held after accept")
    `ASSERT_IMPLIES(a_exec_free, i_clk, i_rst_n, alu_req.start, !alu_rsp.busy, "shared unit busy")

endmodule
